>>> rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// shared types, constants and helper functions of the hybrid branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package bhp_pkg;

   localparam int PC_W        = 32;
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int FIFO_DEPTH  = 3;

   localparam logic [CFG_W-1:0] CHOOSER_BITS_RESET = 4'd8;
   localparam logic [CFG_W-1:0] GSHARE_BITS_RESET  = 4'd10;
   localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd6;
   localparam logic [CFG_W-1:0] BIMODAL_BITS_RESET = 4'd10;

   localparam logic [1:0] CTR_MAX           = 2'd3;
   localparam logic [1:0] CTR_MIN           = 2'd0;
   localparam logic [1:0] CHOOSER_CTR_RESET = 2'd1;
   localparam logic [1:0] GSHARE_CTR_RESET  = 2'd2;
   localparam logic [1:0] BIMODAL_CTR_RESET = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHOOSER_BITS = 4'd0,
      CSR_GSHARE_BITS  = 4'd1,
      CSR_HISTORY_BITS = 4'd2,
      CSR_BIMODAL_BITS = 4'd3
   } bhp_csr_index_type;

   typedef struct packed {
      logic predicted_taken;
      logic mispredicted;
      logic used_gshare;
   } bhp_rsp_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
      logic       empty;
   } bhp_fifo_stat_type;

   // 2-bit saturating counter step
   function automatic logic [1:0] train(input logic [1:0] ctr, input logic up);
      if (up) begin
         return (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
      end
      return (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bhp_if.sv
// ----------------------------------------------------------------------------
// bhp_if
// valid/ready channels of the hybrid branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

interface bhp_req_if;
   logic                      valid;
   logic                      ready;
   logic [bhp_pkg::PC_W-1:0]  pc;
   logic                      taken;

   modport source (output valid, output pc, output taken, input ready);
   modport sink   (input valid, input pc, input taken, output ready);
endinterface

interface bhp_rsp_if;
   logic valid;
   logic ready;
   logic predicted_taken;
   logic mispredicted;
   logic used_gshare;

   modport source (output valid, output predicted_taken, output mispredicted,
                   output used_gshare, input ready);
   modport sink   (input valid, input predicted_taken, input mispredicted,
                   input used_gshare, output ready);
endinterface

`default_nettype wire

>>> rtl/bhp_counter_table.sv
// ----------------------------------------------------------------------------
// bhp_counter_table
// table of 2-bit counters, one read and one write port, write-first bypass
// ----------------------------------------------------------------------------
`default_nettype none

module bhp_counter_table #(
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [1:0]        rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [1:0]        wr_data
);

   logic [1:0] mem [2**ADDR_W];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-entry write in the read cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bhp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// bhp_rsp_fifo
// small result queue between the update stage and the response channel
// ----------------------------------------------------------------------------
`default_nettype none

module bhp_rsp_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire bhp_pkg::bhp_rsp_type       push_data,
   input  wire logic                       pop,
   output bhp_pkg::bhp_rsp_type            pop_data,
   output bhp_pkg::bhp_fifo_stat_type      stat
);

   bhp_pkg::bhp_rsp_type entries_ff [bhp_pkg::FIFO_DEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_in;
   logic [1:0] count_in;

   function automatic logic [1:0] next_ptr(input logic [1:0] ptr);
      return (ptr == 2'(bhp_pkg::FIFO_DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entries_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == 2'(bhp_pkg::FIFO_DEPTH));
   assign stat.empty = (count_ff == 2'd0);

endmodule

`default_nettype wire

>>> rtl/hybrid_branch_predictor_top.sv
// ----------------------------------------------------------------------------
// hybrid_branch_predictor_top
// tournament branch predictor: chooser, gshare and bimodal counter tables
// ----------------------------------------------------------------------------
// usage
//   req_chan takes one resolved branch (pc, taken) per transaction
//   rsp_chan returns one transaction per request, in order: predicted_taken,
//   mispredicted and used_gshare
//   csr_wr_en/csr_index/csr_wdata write the four table geometry registers; the
//   user must write only while no request is in flight (block does not enforce)
// pipeline and throughput
//   one request per cycle while req_chan.ready is high; the three tables are
//   read at accept, the update stage writes the trained ones in the next cycle
//   and pushes the result into the queue; same-entry overlap is forwarded
// reset
//   synchronous; afterwards the tables are swept back to their start
//   values, one entry per cycle over 2**MAX_INDEX_BITS entries (4096 at 12),
//   during which req_chan.ready is low
// stall
//   a three-entry result queue holds finished transactions; req_chan.ready
//   drops once the queue plus the update stage would hold more than three
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_branch_predictor_top #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bhp_req_if.sink                                 req_chan,
   bhp_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [bhp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bhp_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int IW      = MAX_INDEX_BITS;
   localparam int CLAMP_W = $clog2(MAX_INDEX_BITS + 1);
   localparam int BW      = (CLAMP_W > bhp_pkg::CFG_W) ? CLAMP_W : bhp_pkg::CFG_W;

   // configuration registers
   logic [bhp_pkg::CFG_W-1:0] chooser_bits_ff;
   logic [bhp_pkg::CFG_W-1:0] gshare_bits_ff;
   logic [bhp_pkg::CFG_W-1:0] history_bits_ff;
   logic [bhp_pkg::CFG_W-1:0] bimodal_bits_ff;

   // accept stage
   logic          accept;
   logic [BW-1:0] cb;
   logic [BW-1:0] gb;
   logic [BW-1:0] bb;
   logic [BW-1:0] hb_raw;
   logic [BW-1:0] hb;
   logic [IW-1:0] pc_idx;
   logic [IW-1:0] hist;
   logic [IW-1:0] ci;
   logic [IW-1:0] gi;
   logic [IW-1:0] bi;
   logic [IW-1:0] ghist_ff;
   logic [IW-1:0] ghist_in;

   // update stage
   logic          s1_valid_ff;
   logic          s1_taken_ff;
   logic [IW-1:0] s1_ci_ff;
   logic [IW-1:0] s1_gi_ff;
   logic [IW-1:0] s1_bi_ff;
   logic [1:0]    chooser_ctr;
   logic [1:0]    gshare_ctr;
   logic [1:0]    bimodal_ctr;
   logic          g_pred;
   logic          b_pred;
   logic          use_g;
   logic          g_right;
   logic          b_right;
   bhp_pkg::bhp_rsp_type s1_rsp;

   // table write ports
   logic          chooser_we;
   logic          gshare_we;
   logic          bimodal_we;
   logic [IW-1:0] chooser_wa;
   logic [IW-1:0] gshare_wa;
   logic [IW-1:0] bimodal_wa;
   logic [1:0]    chooser_wd;
   logic [1:0]    gshare_wd;
   logic [1:0]    bimodal_wd;

   // clearing sweep
   logic          clearing_ff;
   logic [IW-1:0] clr_idx_ff;

   // result queue
   logic                       rsp_pop;
   logic [2:0]                 occupancy;
   bhp_pkg::bhp_rsp_type       rsp_data;
   bhp_pkg::bhp_fifo_stat_type fifo_stat;

   function automatic logic [BW-1:0] clamp_bits(input logic [bhp_pkg::CFG_W-1:0] b);
      logic [BW-1:0] w;
      w = BW'(b);
      return (w > BW'(MAX_INDEX_BITS)) ? BW'(MAX_INDEX_BITS) : w;
   endfunction

   function automatic logic [IW-1:0] low_mask(input logic [BW-1:0] b);
      logic [IW-1:0] m;
      for (int i = 0; i < IW; i++) begin
         m[i] = (BW'(i) < b);
      end
      return m;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chooser_bits_ff <= bhp_pkg::CHOOSER_BITS_RESET;
         gshare_bits_ff  <= bhp_pkg::GSHARE_BITS_RESET;
         history_bits_ff <= bhp_pkg::HISTORY_BITS_RESET;
         bimodal_bits_ff <= bhp_pkg::BIMODAL_BITS_RESET;
      end else if (csr_wr_en) begin
         unique case (bhp_pkg::bhp_csr_index_type'(csr_index))
            bhp_pkg::CSR_CHOOSER_BITS: chooser_bits_ff <= csr_wdata;
            bhp_pkg::CSR_GSHARE_BITS:  gshare_bits_ff  <= csr_wdata;
            bhp_pkg::CSR_HISTORY_BITS: history_bits_ff <= csr_wdata;
            bhp_pkg::CSR_BIMODAL_BITS: bimodal_bits_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // index generation and history update
   assign occupancy      = 3'(fifo_stat.count) + 3'(s1_valid_ff);
   assign req_chan.ready = !clearing_ff && (occupancy <= 3'(bhp_pkg::FIFO_DEPTH - 1));
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      cb     = clamp_bits(chooser_bits_ff);
      gb     = clamp_bits(gshare_bits_ff);
      bb     = clamp_bits(bimodal_bits_ff);
      hb_raw = clamp_bits(history_bits_ff);
      hb     = (hb_raw > gb) ? gb : hb_raw;
      pc_idx = req_chan.pc[IW+1:2];
      hist   = ghist_ff & low_mask(hb);
      ci     = pc_idx & low_mask(cb);
      bi     = pc_idx & low_mask(bb);
      gi     = (pc_idx & low_mask(gb)) ^ (hist << (gb - hb));
      if (!accept) begin
         ghist_in = ghist_ff;
      end else if (hb == BW'(0)) begin
         ghist_in = '0;
      end else begin
         ghist_in = (IW'(req_chan.taken) << (hb - BW'(1))) | (hist >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         ghist_ff    <= ghist_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_taken_ff <= req_chan.taken;
         s1_ci_ff    <= ci;
         s1_gi_ff    <= gi;
         s1_bi_ff    <= bi;
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clearing_ff) begin
         clr_idx_ff <= clr_idx_ff + IW'(1);
         if (&clr_idx_ff) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // prediction and training
   always_comb begin
      g_pred  = gshare_ctr[1];
      b_pred  = bimodal_ctr[1];
      use_g   = chooser_ctr[1];
      g_right = (g_pred == s1_taken_ff);
      b_right = (b_pred == s1_taken_ff);

      s1_rsp.predicted_taken = use_g ? g_pred : b_pred;
      s1_rsp.mispredicted    = (use_g ? g_pred : b_pred) != s1_taken_ff;
      s1_rsp.used_gshare     = use_g;

      if (clearing_ff) begin
         chooser_we = 1'b1;
         gshare_we  = 1'b1;
         bimodal_we = 1'b1;
         chooser_wa = clr_idx_ff;
         gshare_wa  = clr_idx_ff;
         bimodal_wa = clr_idx_ff;
         chooser_wd = bhp_pkg::CHOOSER_CTR_RESET;
         gshare_wd  = bhp_pkg::GSHARE_CTR_RESET;
         bimodal_wd = bhp_pkg::BIMODAL_CTR_RESET;
      end else begin
         chooser_we = s1_valid_ff && (g_right != b_right);
         gshare_we  = s1_valid_ff && use_g;
         bimodal_we = s1_valid_ff && !use_g;
         chooser_wa = s1_ci_ff;
         gshare_wa  = s1_gi_ff;
         bimodal_wa = s1_bi_ff;
         chooser_wd = bhp_pkg::train(chooser_ctr, g_right);
         gshare_wd  = bhp_pkg::train(gshare_ctr, s1_taken_ff);
         bimodal_wd = bhp_pkg::train(bimodal_ctr, s1_taken_ff);
      end
   end

   bhp_counter_table #(.ADDR_W(IW)) u_chooser (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (ci),
      .rd_data (chooser_ctr),
      .wr_en   (chooser_we),
      .wr_addr (chooser_wa),
      .wr_data (chooser_wd)
   );

   bhp_counter_table #(.ADDR_W(IW)) u_gshare (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (gi),
      .rd_data (gshare_ctr),
      .wr_en   (gshare_we),
      .wr_addr (gshare_wa),
      .wr_data (gshare_wd)
   );

   bhp_counter_table #(.ADDR_W(IW)) u_bimodal (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (bi),
      .rd_data (bimodal_ctr),
      .wr_en   (bimodal_we),
      .wr_addr (bimodal_wa),
      .wr_data (bimodal_wd)
   );

   // result queue
   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   bhp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_rsp),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .stat      (fifo_stat)
   );

   assign rsp_chan.valid           = !fifo_stat.empty;
   assign rsp_chan.predicted_taken = rsp_data.predicted_taken;
   assign rsp_chan.mispredicted    = rsp_data.mispredicted;
   assign rsp_chan.used_gshare     = rsp_data.used_gshare;

   // checks
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing_ff |-> !req_chan.ready
   ) else $error("request accepted during table clearing");

   a_accept_reaches_update: assert property (
      @(posedge clock) disable iff (reset) accept |=> s1_valid_ff
   ) else $error("accepted transaction missing from update stage");

   a_no_queue_overflow: assert property (
      @(posedge clock) disable iff (reset) s1_valid_ff |-> !fifo_stat.full
   ) else $error("result pushed into full queue");

   a_clear_sweep_complete: assert property (
      @(posedge clock) disable iff (reset) $fell(clearing_ff) |-> (&$past(clr_idx_ff))
   ) else $error("clearing ended before last entry");

endmodule

`default_nettype wire

>>> test/bhp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhp_tb_pkg
// scoreboard for the hybrid branch predictor: keeps its own copy of the
// chooser, gshare and bimodal counters, the global history and the table
// geometry, predicts each transaction's outcome and checks results in order
// ----------------------------------------------------------------------------

package bhp_tb_pkg;

   import bhp_pkg::*;

   localparam int TABLE_BITS = 12;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;

   class branch_outcome_predictor;
      logic [1:0]            chooser_ctr [TABLE_SIZE];
      logic [1:0]            gshare_ctr  [TABLE_SIZE];
      logic [1:0]            bimodal_ctr [TABLE_SIZE];
      logic [TABLE_BITS-1:0] history;
      logic [CFG_W-1:0]      chooser_bits;
      logic [CFG_W-1:0]      gshare_bits;
      logic [CFG_W-1:0]      history_len;
      logic [CFG_W-1:0]      bimodal_bits;
      bhp_rsp_type           expected_outcomes [$];
      int unsigned           error_count;

      function new();
         foreach (chooser_ctr[i]) begin
            chooser_ctr[i] = 2'd1;
            gshare_ctr[i]  = 2'd2;
            bimodal_ctr[i] = 2'd2;
         end
         history      = '0;
         chooser_bits = 4'd8;
         gshare_bits  = 4'd10;
         history_len  = 4'd6;
         bimodal_bits = 4'd10;
         error_count  = 0;
      endfunction

      function int unsigned usable_bits(logic [CFG_W-1:0] bits);
         return (bits > TABLE_BITS) ? TABLE_BITS : bits;
      endfunction

      function int unsigned pc_slice(logic [PC_W-1:0] pc, int unsigned bits);
         return (pc >> 2) & ((32'd1 << bits) - 32'd1);
      endfunction

      function logic [1:0] saturate(logic [1:0] ctr, logic up);
         if (up) begin
            return (ctr == 2'd3) ? ctr : ctr + 2'd1;
         end
         return (ctr == 2'd0) ? ctr : ctr - 2'd1;
      endfunction

      function void set_config(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_CHOOSER_BITS: chooser_bits = val;
            CSR_GSHARE_BITS:  gshare_bits  = val;
            CSR_HISTORY_BITS: history_len  = val;
            CSR_BIMODAL_BITS: bimodal_bits = val;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_outcomes.size();
      endfunction

      function void note_branch(logic [PC_W-1:0] pc, logic taken);
         int unsigned cb, gb, hb, bb, hist, ci, gi, bi;
         logic        g_pred, b_pred, use_g;
         bhp_rsp_type want;
         cb = usable_bits(chooser_bits);
         gb = usable_bits(gshare_bits);
         bb = usable_bits(bimodal_bits);
         hb = usable_bits(history_len);
         if (hb > gb) begin
            hb = gb;
         end
         hist = history & ((32'd1 << hb) - 32'd1);
         ci = pc_slice(pc, cb);
         bi = pc_slice(pc, bb);
         gi = (pc_slice(pc, gb) ^ (hist << (gb - hb))) & (TABLE_SIZE - 1);
         g_pred = gshare_ctr[gi][1];
         b_pred = bimodal_ctr[bi][1];
         use_g  = chooser_ctr[ci][1];
         want.predicted_taken = use_g ? g_pred : b_pred;
         want.mispredicted    = (want.predicted_taken != taken);
         want.used_gshare     = use_g;
         if (use_g) begin
            gshare_ctr[gi] = saturate(gshare_ctr[gi], taken);
         end else begin
            bimodal_ctr[bi] = saturate(bimodal_ctr[bi], taken);
         end
         if (hb == 0) begin
            history = '0;
         end else begin
            history = TABLE_BITS'((int'(taken) << (hb - 1)) | (hist >> 1));
         end
         if (g_pred == taken && b_pred != taken) begin
            chooser_ctr[ci] = saturate(chooser_ctr[ci], 1'b1);
         end else if (g_pred != taken && b_pred == taken) begin
            chooser_ctr[ci] = saturate(chooser_ctr[ci], 1'b0);
         end
         expected_outcomes.push_back(want);
      endfunction

      function void check_outcome(bhp_rsp_type got);
         bhp_rsp_type want;
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %0b, actual %0b",
                   want.predicted_taken, got.predicted_taken);
            error_count++;
         end
         if (got.mispredicted !== want.mispredicted) begin
            $error("mispredicted: expected %0b, actual %0b",
                   want.mispredicted, got.mispredicted);
            error_count++;
         end
         if (got.used_gshare !== want.used_gshare) begin
            $error("used_gshare: expected %0b, actual %0b",
                   want.used_gshare, got.used_gshare);
            error_count++;
         end
      endfunction
   endclass

endpackage

>>> test/hybrid_branch_predictor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_branch_predictor_top_tb
// drives resolved branches through the predictor under a series of table
// geometries, with random gaps on both channels outside one steady phase, and
// checks every result transaction against the scoreboard's prediction
// ----------------------------------------------------------------------------

module hybrid_branch_predictor_top_tb;

   import bhp_pkg::*;
   import bhp_tb_pkg::*;

   localparam int NUM_PHASES     = 10;
   localparam int NUM_FIXED      = 8;
   localparam int PHASE_ITEMS    = 185;
   localparam int POOL_SIZE      = 12;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;
   logic                   steady = 1'b0;
   int unsigned            quiet_cycles = 0;

   // chooser, gshare, history, bimodal
   logic [CFG_W-1:0] geometry [NUM_FIXED][4] = '{
      '{4'd8,  4'd10, 4'd6,  4'd10},
      '{4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd12, 4'd12, 4'd4,  4'd12},
      '{4'd0,  4'd0,  4'd0,  4'd0},
      '{4'd15, 4'd15, 4'd15, 4'd15},
      '{4'd3,  4'd4,  4'd12, 4'd5},
      '{4'd10, 4'd8,  4'd0,  4'd6},
      '{4'd13, 4'd2,  4'd1,  4'd14}
   };

   branch_outcome_predictor outcome_pred = new();

   bhp_req_if req_chan();
   bhp_rsp_if rsp_chan();

   hybrid_branch_predictor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 36);
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         outcome_pred.note_branch(req_chan.pc, req_chan.taken);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         outcome_pred.check_outcome({rsp_chan.predicted_taken, rsp_chan.mispredicted,
                                     rsp_chan.used_gshare});
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("hybrid_branch_predictor_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_branch(input logic [PC_W-1:0] pc, input logic taken);
      while (!steady && $urandom_range(0, 99) < 36) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pc    <= pc;
      req_chan.taken <= taken;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_outcomes();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outcome_pred.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      outcome_pred.set_config(idx, val);
   endtask

   task automatic apply_geometry(input logic [CFG_W-1:0] cb, input logic [CFG_W-1:0] gb,
                                 input logic [CFG_W-1:0] hb, input logic [CFG_W-1:0] bb);
      write_csr(CSR_CHOOSER_BITS, cb);
      write_csr(CSR_GSHARE_BITS, gb);
      write_csr(CSR_HISTORY_BITS, hb);
      write_csr(CSR_BIMODAL_BITS, bb);
      // unmapped index, must leave the geometry alone
      write_csr(CSR_INDEX_W'($urandom_range(CSR_BIMODAL_BITS + 1, (1 << CSR_INDEX_W) - 1)),
                CFG_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned count, input bit drain_midway);
      logic [PC_W-1:0] pool_pc      [POOL_SIZE];
      logic [7:0]      pool_pattern [POOL_SIZE];
      int unsigned     pool_period  [POOL_SIZE];
      int unsigned     pool_pos     [POOL_SIZE];
      int unsigned     k;
      logic            taken;
      foreach (pool_pc[i]) begin
         pool_pc[i]      = $urandom;
         pool_pattern[i] = 8'($urandom);
         pool_period[i]  = $urandom_range(1, 8);
         pool_pos[i]     = 0;
      end
      for (int n = 0; n < count; n++) begin
         if (drain_midway && n == count / 2) begin
            drain_outcomes();
         end
         // mostly recurring branches with repeating outcome patterns
         if ($urandom_range(0, 99) < 70) begin
            k = $urandom_range(0, POOL_SIZE - 1);
            taken = pool_pattern[k][pool_pos[k] % pool_period[k]] ^
                    ($urandom_range(0, 99) < 8);
            pool_pos[k]++;
            send_branch(pool_pc[k], taken);
         end else begin
            send_branch($urandom, 1'($urandom));
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pc    = '0;
      req_chan.taken = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      repeat (3) send_branch(32'h0000_0100, 1'b1);
      repeat (3) send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h8000_0003, 1'b1);
      send_branch(32'h8000_0003, 1'b0);
      send_branch(32'h8000_0003, 1'b1);
      send_branch(32'h8000_0003, 1'b0);
      repeat (4) send_branch(32'h7FFF_FFFC, 1'b1);
      repeat (3) send_branch(32'h0000_0004, 1'b0);
      drain_outcomes();

      for (int p = 0; p < NUM_PHASES; p++) begin
         steady <= (p == 2);
         if (p < NUM_FIXED) begin
            apply_geometry(geometry[p][0], geometry[p][1], geometry[p][2], geometry[p][3]);
         end else begin
            apply_geometry(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                           CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)));
         end
         run_phase(PHASE_ITEMS, p == 0);
         drain_outcomes();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outcome_pred.error_count == 0 && outcome_pred.pending() == 0) begin
         $display("hybrid_branch_predictor_top_tb OK");
      end else begin
         $display("hybrid_branch_predictor_top_tb NOT OK");
      end
      $finish;
   end

endmodule
